// File: hw/rtl/lbmc_pkg.sv
// ----------------------------------------------------------------------------
// lbmc_pkg
// shared constants of the d2q9 bgk collision pipeline: word format defaults,
// lattice directions and weight classes
// ----------------------------------------------------------------------------
package lbmc_pkg;

	localparam int WORD_BITS  = 32;
	localparam int FRAC_BITS  = 28;
	localparam int NDIR       = 9;
	localparam int RATE_BITS  = 30;
	localparam int OMEGA_BITS = RATE_BITS + 1;

	// order: rest, east, north, west, south, ne, nw, sw, se
	localparam int EX [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
	localparam int EY [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};

	// weight class: rest, axis, diagonal
	function automatic int dir_class(input int k);
		int c;
		c = (k == 0) ? 0 : ((k < 5) ? 1 : 2);
		return c;
	endfunction

endpackage

// File: hw/rtl/lbmc_moments.sv
// ----------------------------------------------------------------------------
// lbmc_moments
// input register and exact density and momentum sums of one cell
// ----------------------------------------------------------------------------
module lbmc_moments #(
	parameter int W = lbmc_pkg::WORD_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [W-1:0] in_dist [lbmc_pkg::NDIR],
	input  logic                in_obst,
	input  logic                in_last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [W-1:0] out_dist [lbmc_pkg::NDIR],
	output logic                out_obst,
	output logic                out_last,
	output logic signed [W+3:0] out_rho,
	output logic signed [W+3:0] out_mx,
	output logic signed [W+3:0] out_my
);
	import lbmc_pkg::*;

	localparam int SA = W + 4;

	logic v_s1, v_s2, en1, en2;
	logic signed [W-1:0] dist_s1 [NDIR];
	logic obst_s1, last_s1;
	logic signed [SA-1:0] rho_c, mx_c, my_c;

	assign en2      = ~v_s2 | out_ready;
	assign en1      = ~v_s1 | en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			dist_s1 <= in_dist;
			obst_s1 <= in_obst;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		rho_c = '0;
		mx_c  = '0;
		my_c  = '0;
		for (int k = 0; k < NDIR; k++) begin
			rho_c = rho_c + SA'(dist_s1[k]);
			if (EX[k] == 1) mx_c = mx_c + SA'(dist_s1[k]);
			else if (EX[k] == -1) mx_c = mx_c - SA'(dist_s1[k]);
			if (EY[k] == 1) my_c = my_c + SA'(dist_s1[k]);
			else if (EY[k] == -1) my_c = my_c - SA'(dist_s1[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			out_dist <= dist_s1;
			out_obst <= obst_s1;
			out_last <= last_s1;
			out_rho  <= rho_c;
			out_mx   <= mx_c;
			out_my   <= my_c;
		end
	end

	assign out_valid = v_s2;

endmodule

// File: hw/rtl/lbmc_div.sv
// ----------------------------------------------------------------------------
// lbmc_div
// two-lane pipelined restoring divider, one quotient bit per stage,
// fixed-point quotient truncated toward zero and saturated
// ----------------------------------------------------------------------------
module lbmc_div #(
	parameter int W      = lbmc_pkg::WORD_BITS,
	parameter int F      = lbmc_pkg::FRAC_BITS,
	parameter int SIDE_W = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [W+3:0] in_num_x,
	input  logic signed [W+3:0] in_num_y,
	input  logic signed [W+3:0] in_den,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [W-1:0] out_quo_x,
	output logic signed [W-1:0] out_quo_y,
	output logic [SIDE_W-1:0]   out_side
);
	import lbmc_pkg::*;

	localparam int NA  = W + 4;
	localparam int DWD = 2 * W + F + 8;
	localparam int NST = W + 2;
	localparam logic [W-1:0] HALFW = W'(1) << (W - 1);

	logic [NST-1:0] v_s;
	logic [NST:0]   en;

	logic [DWD-1:0] rem_x_s [W+1];
	logic [DWD-1:0] rem_y_s [W+1];
	logic [DWD-1:0] den_s   [W+1];
	logic [W-1:0]   q_x_s   [W+1];
	logic [W-1:0]   q_y_s   [W+1];
	logic           neg_x_s [W+1];
	logic           neg_y_s [W+1];
	logic           ovf_x_s [W+1];
	logic           ovf_y_s [W+1];
	logic [SIDE_W-1:0] side_s [NST];
	logic signed [W-1:0] quo_x_s, quo_y_s;

	logic [NA-1:0]  mag_x, mag_y;
	logic [DWD-1:0] num_x_w, num_y_w, den_w;

	assign en[NST] = out_ready;
	for (genvar j = 0; j < NST; j++) begin : g_en
		assign en[j] = ~v_s[j] | en[j+1];
	end
	assign in_ready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			if (en[0]) v_s[0] <= in_valid;
			for (int j = 1; j < NST; j++)
				if (en[j]) v_s[j] <= v_s[j-1];
		end
	end

	always_comb begin
		mag_x   = in_num_x[NA-1] ? NA'(-in_num_x) : NA'(in_num_x);
		mag_y   = in_num_y[NA-1] ? NA'(-in_num_y) : NA'(in_num_y);
		num_x_w = DWD'(mag_x) << F;
		num_y_w = DWD'(mag_y) << F;
		den_w   = DWD'(in_den[NA-1:0]);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rem_x_s[0] <= num_x_w;
			rem_y_s[0] <= num_y_w;
			den_s[0]   <= den_w;
			q_x_s[0]   <= '0;
			q_y_s[0]   <= '0;
			neg_x_s[0] <= in_num_x[NA-1];
			neg_y_s[0] <= in_num_y[NA-1];
			ovf_x_s[0] <= num_x_w >= (den_w << W);
			ovf_y_s[0] <= num_y_w >= (den_w << W);
			side_s[0]  <= in_side;
		end
	end

	for (genvar j = 1; j <= W; j++) begin : g_step
		localparam int B = W - j;
		logic [DWD-1:0] dsh;
		logic           take_x, take_y;
		logic [W-1:0]   nq_x, nq_y;

		always_comb begin
			dsh     = den_s[j-1] << B;
			take_x  = rem_x_s[j-1] >= dsh;
			take_y  = rem_y_s[j-1] >= dsh;
			nq_x    = q_x_s[j-1];
			nq_y    = q_y_s[j-1];
			nq_x[B] = take_x;
			nq_y[B] = take_y;
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_x_s[j] <= take_x ? rem_x_s[j-1] - dsh : rem_x_s[j-1];
				rem_y_s[j] <= take_y ? rem_y_s[j-1] - dsh : rem_y_s[j-1];
				den_s[j]   <= den_s[j-1];
				q_x_s[j]   <= nq_x;
				q_y_s[j]   <= nq_y;
				neg_x_s[j] <= neg_x_s[j-1];
				neg_y_s[j] <= neg_y_s[j-1];
				ovf_x_s[j] <= ovf_x_s[j-1];
				ovf_y_s[j] <= ovf_y_s[j-1];
				side_s[j]  <= side_s[j-1];
			end
		end
	end

	logic [W-1:0] lim_x, lim_y, qc_x, qc_y;

	always_comb begin
		lim_x = neg_x_s[W] ? HALFW : HALFW - W'(1);
		lim_y = neg_y_s[W] ? HALFW : HALFW - W'(1);
		qc_x  = (ovf_x_s[W] || q_x_s[W] > lim_x) ? lim_x : q_x_s[W];
		qc_y  = (ovf_y_s[W] || q_y_s[W] > lim_y) ? lim_y : q_y_s[W];
	end

	always_ff @(posedge clk) begin
		if (en[W+1]) begin
			quo_x_s      <= neg_x_s[W] ? -qc_x : qc_x;
			quo_y_s      <= neg_y_s[W] ? -qc_y : qc_y;
			side_s[W+1]  <= side_s[W];
		end
	end

	assign out_valid = v_s[W+1];
	assign out_quo_x = quo_x_s;
	assign out_quo_y = quo_y_s;
	assign out_side  = side_s[W+1];

endmodule

// File: hw/rtl/lbmc_equil.sv
// ----------------------------------------------------------------------------
// lbmc_equil
// equilibrium and relaxation pipeline: velocity products, polynomial,
// weighted equilibrium, bgk relaxation and pass-through select
// ----------------------------------------------------------------------------
module lbmc_equil #(
	parameter int W  = lbmc_pkg::WORD_BITS,
	parameter int F  = lbmc_pkg::FRAC_BITS,
	parameter int OB = lbmc_pkg::OMEGA_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [OB-1:0]       omega,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [W-1:0] in_ux,
	input  logic signed [W-1:0] in_uy,
	input  logic [10*W+2:0]     in_side,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [W-1:0] out_f [lbmc_pkg::NDIR],
	output logic                out_fault,
	output logic                out_last
);
	import lbmc_pkg::*;

	localparam int SW  = 10 * W + 3;
	localparam int PW  = 2 * W + 8;
	localparam int RHO = 9 * W;
	localparam int OBS = 10 * W;
	localparam int FLT = 10 * W + 1;
	localparam int LST = 10 * W + 2;

	localparam logic [PW-1:0] HALF = PW'(1) << (W - 1);
	localparam logic signed [PW-1:0] SMAX = signed'(HALF - PW'(1));
	localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);

	localparam longint WMAX_L = (longint'(1) <<< (W - 1)) - 1;
	localparam longint ONE_L  = longint'(1) <<< F;
	localparam longint W0_L   = ((longint'(4) <<< F) + 4) / 9;
	localparam longint W1_L   = ((longint'(1) <<< F) + 4) / 9;
	localparam longint W2_L   = ((longint'(1) <<< F) + 18) / 36;
	localparam logic signed [W-1:0] ONE_W = W'(ONE_L > WMAX_L ? WMAX_L : ONE_L);
	localparam logic [W-1:0] WT0 = W'(W0_L > WMAX_L ? WMAX_L : W0_L);
	localparam logic [W-1:0] WT1 = W'(W1_L > WMAX_L ? WMAX_L : W1_L);
	localparam logic [W-1:0] WT2 = W'(W2_L > WMAX_L ? WMAX_L : W2_L);

	function automatic logic signed [PW-1:0] ext(input logic signed [W-1:0] x);
		return PW'(x);
	endfunction

	function automatic logic [W-1:0] mag(input logic signed [W-1:0] x);
		logic [W-1:0] m;
		m = x[W-1] ? W'(-x) : W'(x);
		return m;
	endfunction

	function automatic logic signed [W-1:0] satw(input logic signed [PW-1:0] v);
		logic signed [W-1:0] r;
		if (v > SMAX) r = SMAX[W-1:0];
		else if (v < SMIN) r = SMIN[W-1:0];
		else r = v[W-1:0];
		return r;
	endfunction

	function automatic logic [PW-1:0] mulmag(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [2*W-1:0] t;
		t = a * b;
		return PW'(t);
	endfunction

	function automatic logic [PW-1:0] mulom(input logic [OB-1:0] a, input logic [W-1:0] b);
		logic [OB+W-1:0] t;
		t = a * b;
		return PW'(t);
	endfunction

	function automatic logic signed [W-1:0] mul_fin(input logic [PW-1:0] p, input logic neg);
		logic [PW-1:0] r, lim;
		r   = p >> F;
		lim = neg ? HALF : HALF - PW'(1);
		if (r > lim) r = lim;
		return neg ? W'(PW'(0) - r) : W'(r);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic en1, en2, en3, en4, en5, en6, en7, en8;

	assign en8      = ~v_s8 | out_ready;
	assign en7      = ~v_s7 | en8;
	assign en6      = ~v_s6 | en7;
	assign en5      = ~v_s5 | en6;
	assign en4      = ~v_s4 | en5;
	assign en3      = ~v_s3 | en4;
	assign en2      = ~v_s2 | en3;
	assign en1      = ~v_s1 | en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
			if (en8) v_s8 <= v_s7;
		end
	end

	logic [SW-1:0] side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7;

	// stage 1: lattice projections of the velocity
	logic signed [W-1:0] ux_s1, uy_s1;
	logic signed [W-1:0] eu_s1 [NDIR];
	logic signed [PW-1:0] eu_acc [NDIR];

	always_comb begin
		for (int k = 0; k < NDIR; k++) begin
			eu_acc[k] = '0;
			if (EX[k] == 1) eu_acc[k] = eu_acc[k] + ext(in_ux);
			else if (EX[k] == -1) eu_acc[k] = eu_acc[k] - ext(in_ux);
			if (EY[k] == 1) eu_acc[k] = eu_acc[k] + ext(in_uy);
			else if (EY[k] == -1) eu_acc[k] = eu_acc[k] - ext(in_uy);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			ux_s1   <= in_ux;
			uy_s1   <= in_uy;
			side_s1 <= in_side;
			for (int k = 0; k < NDIR; k++) eu_s1[k] <= satw(eu_acc[k]);
		end
	end

	// stage 2: squares and weighted density products
	logic [PW-1:0] psx_s2, psy_s2;
	logic [PW-1:0] pe_s2 [NDIR];
	logic [PW-1:0] pw_s2 [3];
	logic          negw_s2;
	logic signed [W-1:0] t3_s2 [NDIR];
	logic signed [W-1:0] rho_s1;

	assign rho_s1 = signed'(side_s1[RHO +: W]);

	always_ff @(posedge clk) begin
		if (en2) begin
			psx_s2  <= mulmag(mag(ux_s1), mag(ux_s1));
			psy_s2  <= mulmag(mag(uy_s1), mag(uy_s1));
			pw_s2[0] <= mulmag(WT0, mag(rho_s1));
			pw_s2[1] <= mulmag(WT1, mag(rho_s1));
			pw_s2[2] <= mulmag(WT2, mag(rho_s1));
			negw_s2 <= rho_s1[W-1];
			side_s2 <= side_s1;
			for (int k = 0; k < NDIR; k++) begin
				pe_s2[k] <= mulmag(mag(eu_s1[k]), mag(eu_s1[k]));
				t3_s2[k] <= satw(3 * ext(eu_s1[k]));
			end
		end
	end

	// stage 3: scale products, u.u and 4.5 (e.u)^2
	logic signed [W-1:0] usq_s3;
	logic signed [W-1:0] t45_s3 [NDIR];
	logic signed [W-1:0] t3_s3 [NDIR];
	logic signed [W-1:0] wr_s3 [3];

	always_ff @(posedge clk) begin
		if (en3) begin
			usq_s3 <= satw(ext(mul_fin(psx_s2, 1'b0)) + ext(mul_fin(psy_s2, 1'b0)));
			for (int c = 0; c < 3; c++) wr_s3[c] <= mul_fin(pw_s2[c], negw_s2);
			for (int k = 0; k < NDIR; k++) begin
				t45_s3[k] <= satw((9 * ext(mul_fin(pe_s2[k], 1'b0))) >>> 1);
				t3_s3[k]  <= t3_s2[k];
			end
			side_s3 <= side_s2;
		end
	end

	// stage 4: equilibrium polynomial
	logic signed [W-1:0] half_c;
	logic signed [W-1:0] poly_s4 [NDIR];
	logic signed [W-1:0] wr_s4 [3];

	assign half_c = satw((3 * ext(usq_s3)) >>> 1);

	always_ff @(posedge clk) begin
		if (en4) begin
			for (int k = 0; k < NDIR; k++)
				poly_s4[k] <= satw(ext(ONE_W) + ext(t3_s3[k]) + ext(t45_s3[k]) - ext(half_c));
			wr_s4   <= wr_s3;
			side_s4 <= side_s3;
		end
	end

	// stage 5: weight times polynomial
	logic [PW-1:0] pf_s5 [NDIR];
	logic          nf_s5 [NDIR];

	always_ff @(posedge clk) begin
		if (en5) begin
			for (int k = 0; k < NDIR; k++) begin
				pf_s5[k] <= mulmag(mag(wr_s4[dir_class(k)]), mag(poly_s4[k]));
				nf_s5[k] <= wr_s4[dir_class(k)][W-1] ^ poly_s4[k][W-1];
			end
			side_s5 <= side_s4;
		end
	end

	// stage 6: distance to equilibrium
	logic signed [W-1:0] d_s6 [NDIR];

	always_ff @(posedge clk) begin
		if (en6) begin
			for (int k = 0; k < NDIR; k++)
				d_s6[k] <= satw(ext(mul_fin(pf_s5[k], nf_s5[k]))
					- ext(signed'(side_s5[k*W +: W])));
			side_s6 <= side_s5;
		end
	end

	// stage 7: relaxation product
	logic [PW-1:0] pm_s7 [NDIR];
	logic          nm_s7 [NDIR];

	always_ff @(posedge clk) begin
		if (en7) begin
			for (int k = 0; k < NDIR; k++) begin
				pm_s7[k] <= mulom(omega, mag(d_s6[k]));
				nm_s7[k] <= d_s6[k][W-1];
			end
			side_s7 <= side_s6;
		end
	end

	// stage 8: update or pass through
	logic pass_c;
	logic signed [W-1:0] f_c [NDIR];

	assign pass_c = side_s7[OBS] | side_s7[FLT];

	always_comb begin
		for (int k = 0; k < NDIR; k++) f_c[k] = signed'(side_s7[k*W +: W]);
	end

	always_ff @(posedge clk) begin
		if (en8) begin
			for (int k = 0; k < NDIR; k++)
				out_f[k] <= pass_c ? f_c[k]
					: satw(ext(f_c[k]) + ext(mul_fin(pm_s7[k], nm_s7[k])));
			out_fault <= side_s7[FLT];
			out_last  <= side_s7[LST];
		end
	end

	assign out_valid = v_s8;

endmodule

// File: hw/rtl/lbm_d2q9_bgk_collision_top.sv
// ----------------------------------------------------------------------------
// lbm_d2q9_bgk_collision_top
// d2q9 lattice boltzmann bgk collision, one cell per clock while out_ready is high, fixed point
// ----------------------------------------------------------------------------
// usage:
// - input channel in_valid/in_ready carries one cell request: nine
//   distributions, is_obstacle and last_cell
// - output channel out_valid/out_ready returns the relaxed distributions,
//   density_fault and end_of_tile, in request order
// - cfg_valid/cfg_ready writes relax_rate (omega); cfg_ready is always high,
//   write only while the pipeline is empty
// - throughput: one cell per cycle while out_ready is high, no bubbles between cells
// - the divider forms one velocity quotient bit per stage
// - obstacle cells and cells of non-positive density pass unchanged
// - reset clears all stage valid bits and loads omega with 1.0
// - when out_ready is low, stages fill up behind the output register and
//   in_ready falls only once every stage holds a cell; nothing is dropped
// ----------------------------------------------------------------------------
module lbm_d2q9_bgk_collision_top #(
	parameter int WORD_BITS = lbmc_pkg::WORD_BITS,
	parameter int FRAC_BITS = lbmc_pkg::FRAC_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [lbmc_pkg::RATE_BITS-1:0] relax_rate,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [WORD_BITS-1:0] dist_rest,
	input  logic signed [WORD_BITS-1:0] dist_east,
	input  logic signed [WORD_BITS-1:0] dist_north,
	input  logic signed [WORD_BITS-1:0] dist_west,
	input  logic signed [WORD_BITS-1:0] dist_south,
	input  logic signed [WORD_BITS-1:0] dist_northeast,
	input  logic signed [WORD_BITS-1:0] dist_northwest,
	input  logic signed [WORD_BITS-1:0] dist_southwest,
	input  logic signed [WORD_BITS-1:0] dist_southeast,
	input  logic                        is_obstacle,
	input  logic                        last_cell,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [WORD_BITS-1:0] new_rest,
	output logic signed [WORD_BITS-1:0] new_east,
	output logic signed [WORD_BITS-1:0] new_north,
	output logic signed [WORD_BITS-1:0] new_west,
	output logic signed [WORD_BITS-1:0] new_south,
	output logic signed [WORD_BITS-1:0] new_northeast,
	output logic signed [WORD_BITS-1:0] new_northwest,
	output logic signed [WORD_BITS-1:0] new_southwest,
	output logic signed [WORD_BITS-1:0] new_southeast,
	output logic                        density_fault,
	output logic                        end_of_tile
);
	import lbmc_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int SA = W + 4;
	localparam int SW = 10 * W + 3;
	localparam logic [OMEGA_BITS-1:0] RATE_RESET = OMEGA_BITS'(longint'(1) <<< FRAC_BITS);
	localparam logic signed [SA-1:0] RMAX = SA'((longint'(1) <<< (W - 1)) - 1);
	localparam logic signed [SA-1:0] RMIN = -RMAX - SA'(1);

	logic [OMEGA_BITS-1:0] relax_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) relax_q <= RATE_RESET;
		else if (cfg_valid) relax_q <= OMEGA_BITS'(relax_rate);
	end

	logic signed [W-1:0] dist_a [NDIR];
	logic signed [W-1:0] mdist [NDIR];
	logic signed [W-1:0] res_f [NDIR];
	logic m_valid, m_ready, m_obst, m_last;
	logic signed [SA-1:0] m_rho, m_mx, m_my;

	assign dist_a[0] = dist_rest;
	assign dist_a[1] = dist_east;
	assign dist_a[2] = dist_north;
	assign dist_a[3] = dist_west;
	assign dist_a[4] = dist_south;
	assign dist_a[5] = dist_northeast;
	assign dist_a[6] = dist_northwest;
	assign dist_a[7] = dist_southwest;
	assign dist_a[8] = dist_southeast;

	lbmc_moments #(.W(W)) u_moments (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_dist   (dist_a),
		.in_obst   (is_obstacle),
		.in_last   (last_cell),
		.out_valid (m_valid),
		.out_ready (m_ready),
		.out_dist  (mdist),
		.out_obst  (m_obst),
		.out_last  (m_last),
		.out_rho   (m_rho),
		.out_mx    (m_mx),
		.out_my    (m_my)
	);

	logic signed [W-1:0] rho_sat;
	logic fault_c;
	logic [SW-1:0] side_in, side_out;

	always_comb begin
		if (m_rho > RMAX) rho_sat = RMAX[W-1:0];
		else if (m_rho < RMIN) rho_sat = RMIN[W-1:0];
		else rho_sat = m_rho[W-1:0];
		fault_c = ~m_obst & (m_rho <= SA'(0));
		for (int k = 0; k < NDIR; k++) side_in[k*W +: W] = mdist[k];
		side_in[9*W +: W] = rho_sat;
		side_in[10*W]     = m_obst;
		side_in[10*W+1]   = fault_c;
		side_in[10*W+2]   = m_last;
	end

	logic d_valid, d_ready;
	logic signed [W-1:0] ux, uy;

	lbmc_div #(.W(W), .F(FRAC_BITS), .SIDE_W(SW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (m_valid),
		.in_ready  (m_ready),
		.in_num_x  (m_mx),
		.in_num_y  (m_my),
		.in_den    (m_rho),
		.in_side   (side_in),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_quo_x (ux),
		.out_quo_y (uy),
		.out_side  (side_out)
	);

	lbmc_equil #(.W(W), .F(FRAC_BITS), .OB(OMEGA_BITS)) u_equil (
		.clk       (clk),
		.arst_n    (arst_n),
		.omega     (relax_q),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_ux     (ux),
		.in_uy     (uy),
		.in_side   (side_out),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_f     (res_f),
		.out_fault (density_fault),
		.out_last  (end_of_tile)
	);

	assign new_rest      = res_f[0];
	assign new_east      = res_f[1];
	assign new_north     = res_f[2];
	assign new_west      = res_f[3];
	assign new_south     = res_f[4];
	assign new_northeast = res_f[5];
	assign new_northwest = res_f[6];
	assign new_southwest = res_f[7];
	assign new_southeast = res_f[8];

endmodule
